@@ rtl/swrs_pkg.sv @@
package swrs_pkg;

    localparam int MAX_SAMPLES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int IN_SAMPLE_BITS  = 16;
    localparam int TIME_BITS       = 24;
    localparam int METRIC_BITS     = 48;
    localparam int FRAC_BITS       = 24;
    localparam int HYP_FRAC_SHIFT  = 16;
    localparam int RMS_SHIFT       = 48;
    localparam int TWO_PI_SHIFT    = 29;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;
    localparam int RECIP_SHIFT     = 64;
    localparam logic [63:0] TWO_PI_RECIP =
        64'((128'd1 << (TWO_PI_SHIFT + RECIP_SHIFT)) / 128'(TWO_PI_Q29));

    typedef enum logic [1:0] {
        ARITH_MUL,
        ARITH_DIV,
        ARITH_SQRT
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } arith_rsp_t;

    typedef enum logic [3:0] {
        MET_XRANGE,
        MET_YRANGE,
        MET_XVEL,
        MET_YVEL,
        MET_PATH,
        MET_XRMS,
        MET_YRMS,
        MET_DIST,
        MET_PATH_2PI
    } metric_t;

endpackage

@@ rtl/swrs_arith.sv @@
module swrs_arith #(
    parameter int W = 128
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  swrs_pkg::arith_ctl_t  ctl,
    input  logic [W-1:0]          op_a,
    input  logic [W-1:0]          op_b,
    output swrs_pkg::arith_rsp_t  rsp,
    output logic [W-1:0]          result
);

    localparam int CNTW = $clog2(W + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    swrs_pkg::arith_op_t op_reg, op_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        a_reg, a_next;
    logic [W-1:0]        b_reg, b_next;
    logic [W:0]          rem_reg, rem_next;
    logic [W:0]          trial;
    logic [W:0]          part;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        trial     = '0;
        part      = '0;
        if (ctl.start && !busy_reg) begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            a_next    = op_a;
            b_next    = op_b;
            acc_next  = '0;
            rem_next  = '0;
            cnt_next  = (ctl.op == swrs_pkg::ARITH_DIV) ? CNTW'(W) : CNTW'(W / 2);
        end else if (busy_reg) begin
            case (op_reg)
                swrs_pkg::ARITH_MUL: begin
                    if (b_reg == '0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        if (b_reg[0]) begin
                            acc_next = acc_reg + a_reg;
                        end
                        a_next = a_reg << 1;
                        b_next = b_reg >> 1;
                    end
                end
                swrs_pkg::ARITH_DIV: begin
                    part = {rem_reg[W-1:0], a_reg[W-1]};
                    if (part >= {1'b0, b_reg}) begin
                        rem_next = part - {1'b0, b_reg};
                        acc_next = {acc_reg[W-2:0], 1'b1};
                    end else begin
                        rem_next = part;
                        acc_next = {acc_reg[W-2:0], 1'b0};
                    end
                    a_next   = a_reg << 1;
                    cnt_next = cnt_reg - CNTW'(1);
                    if (cnt_reg == CNTW'(1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                swrs_pkg::ARITH_SQRT: begin
                    part  = {rem_reg[W-2:0], a_reg[W-1:W-2]};
                    trial = {acc_reg[W-2:0], 2'b01};
                    if (part >= trial) begin
                        rem_next = part - trial;
                        acc_next = {acc_reg[W-2:0], 1'b1};
                    end else begin
                        rem_next = part;
                        acc_next = {acc_reg[W-2:0], 1'b0};
                    end
                    a_next   = a_reg << 2;
                    cnt_next = cnt_reg - CNTW'(1);
                    if (cnt_reg == CNTW'(1)) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= swrs_pkg::ARITH_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign result   = acc_reg;

endmodule

@@ rtl/sway_record_statistics_top.sv @@
// Sway record statistics.
// Input channel s_*: one transaction per sample; s_tdata carries x, y and the
// time stamp, s_tlast closes the record. Samples are written to two sample
// memories and running sums are kept as they arrive.
// Output channel m_*: nine transactions per closed record, metric 0 to 8 in
// order, m_tlast on the ninth; m_tuser carries the metric index and the
// invalid flag.
// Sample handling: the first sample of a record is taken without a stall; every
// later sample holds off the next one while the shared serial
// multiply/square-root unit computes the step length and the distance.
// After the closing sample of a valid record: three serial multiplies, a
// multiply and a divide per velocity metric, one divide each for path and
// distance, two multiplies by constants with a one-step correction for
// path / (2 pi), and for each RMS metric one pass over the stored samples but
// the last, followed by a divide and a square root. WID is the larger of
// 2*SAMPLE_BITS + 3*CW + 48 and 112, rounded up to even.
// No sample is taken while the record is being closed or while a metric
// waits on m_tready; a stalled metric holds on the port.
// Reset clears the record; the sample memories need no clearing.
module sway_record_statistics_top #(
    parameter int MAX_SAMPLES = swrs_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = swrs_pkg::SAMPLE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // x_sample[15:0], y_sample[31:16], time_stamp[55:32]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // metric_value[47:0]
    output logic [4:0]  m_tuser,   // metric_index[3:0], invalid[4]
    output logic        m_tlast
);

    localparam int SB   = SAMPLE_BITS;
    localparam int IW   = swrs_pkg::IN_SAMPLE_BITS;
    localparam int TW   = swrs_pkg::TIME_BITS;
    localparam int MB   = swrs_pkg::METRIC_BITS;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int WQ   = 2 * SB + 3 * CW;
    localparam int L1   = WQ + swrs_pkg::RMS_SHIFT;
    localparam int L2   = MB + swrs_pkg::RECIP_SHIFT;
    localparam int L3   = SB + 2 * CW + swrs_pkg::FRAC_BITS;
    localparam int L4   = SB + CW + 9 + swrs_pkg::HYP_FRAC_SHIFT;
    localparam int M12  = (L1 > L2) ? L1 : L2;
    localparam int M34  = (L3 > L4) ? L3 : L4;
    localparam int WM   = (M12 > M34) ? M12 : M34;
    localparam int WID  = WM + (WM % 2);
    localparam int SW   = SB + CW + 2;
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_HMA, S_HMB, S_HSQ, S_FIN, S_TM, S_NN, S_MNN,
        S_MST, S_VMUL, S_RRD, S_RE, S_RSQ, S_DIV, S_SQ, S_OUT,
        S_RMUL, S_RBK
    } state_t;

    state_t                 state_reg, state_next;
    logic                   issued_reg, issued_next;
    logic [CW-1:0]          count_reg, count_next;
    logic                   ovf_reg, ovf_next;
    logic signed [SB-1:0]   xl_reg, xl_next, xh_reg, xh_next;
    logic signed [SB-1:0]   yl_reg, yl_next, yh_reg, yh_next;
    logic [TW-1:0]          t_reg, t_next;
    logic [SB+CW-1:0]       sstx_reg, sstx_next, ssty_reg, ssty_next;
    logic [SB+CW+8:0]       spath_reg, spath_next;
    logic [SB+CW+7:0]       sdist_reg, sdist_next;
    logic signed [SB+CW-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic                   sel_reg, sel_next;
    logic                   last_reg, last_next;
    swrs_pkg::metric_t      k_reg, k_next;
    logic                   bad_reg, bad_next;
    logic [CW-1:0]          idx_reg, idx_next;

    logic signed [SB-1:0]   prevx_reg, prevx_next, prevy_reg, prevy_next;
    logic [SB-1:0]          ha_reg, ha_next, hb_reg, hb_next;
    logic [SB-1:0]          pa_reg, pa_next, pb_reg, pb_next;
    logic [2*SB:0]          hsum_reg, hsum_next;
    logic [SB+CW:0]         e_reg, e_next;
    logic [WQ-1:0]          q_reg, q_next;
    logic [WID-1:0]         tmp_reg, tmp_next;
    logic [TW+CW-1:0]       dvel_reg, dvel_next;
    logic [3*CW-1:0]        drms_reg, drms_next;
    logic [MB-1:0]          v4_reg, v4_next;
    logic [MB-1:0]          val_reg, val_next;

    logic [SB-1:0]          x_mem [MAX_SAMPLES];
    logic [SB-1:0]          y_mem [MAX_SAMPLES];
    logic [SB-1:0]          rdx_reg, rdy_reg;
    logic                   mem_we;
    logic [AW-1:0]          raddr;

    logic [IW+SB-1:0]       xe, ye;
    logic signed [SB-1:0]   xs, ys;
    logic signed [SB:0]     dx, dy;
    logic [SB:0]            adx, ady, apx, apy;
    logic signed [CW+SB:0]  prod;
    logic signed [SW-1:0]   ediff;
    logic [SW-1:0]          eabs;
    logic [CW-1:0]          n_val, m_val;
    logic signed [SB:0]     xdiff, ydiff;
    logic                   accept, clear, bad;
    logic [WID-1:0]         prem;

    swrs_pkg::arith_ctl_t   actl;
    swrs_pkg::arith_rsp_t   arsp;
    logic [WID-1:0]         aa, ab, ares;
    logic                   arith_use;

    function automatic logic [MB-1:0] sat48(input logic [WID-1:0] v);
        return (|v[WID-1:MB]) ? {MB{1'b1}} : v[MB-1:0];
    endfunction

    swrs_arith #(
        .W (WID)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (actl),
        .op_a    (aa),
        .op_b    (ab),
        .rsp     (arsp),
        .result  (ares)
    );

    assign xe     = {{SB{1'b0}}, s_tdata[IW-1:0]};
    assign ye     = {{SB{1'b0}}, s_tdata[2*IW-1:IW]};
    assign xs     = $signed(xe[SB-1:0]);
    assign ys     = $signed(ye[SB-1:0]);
    assign dx     = (SB+1)'(xs) - (SB+1)'(prevx_reg);
    assign dy     = (SB+1)'(ys) - (SB+1)'(prevy_reg);
    assign adx    = dx[SB] ? (SB+1)'(-dx) : (SB+1)'(dx);
    assign ady    = dy[SB] ? (SB+1)'(-dy) : (SB+1)'(dy);
    assign apx    = prevx_reg[SB-1] ? (SB+1)'(-(SB+1)'(prevx_reg)) : (SB+1)'(prevx_reg);
    assign apy    = prevy_reg[SB-1] ? (SB+1)'(-(SB+1)'(prevy_reg)) : (SB+1)'(prevy_reg);
    assign n_val  = count_reg;
    assign m_val  = count_reg - CW'(1);
    assign xdiff  = (SB+1)'(xh_reg) - (SB+1)'(xl_reg);
    assign ydiff  = (SB+1)'(yh_reg) - (SB+1)'(yl_reg);
    assign prod   = $signed({1'b0, count_reg}) * (sel_reg ? $signed(rdy_reg) : $signed(rdx_reg));
    assign ediff  = SW'(prod) - SW'(sel_reg ? sy_reg : sx_reg);
    assign eabs   = ediff[SW-1] ? SW'(-ediff) : SW'(ediff);
    assign raddr  = idx_reg[AW-1:0];
    assign bad    = (count_reg < CW'(2)) || (t_reg == '0) || ovf_reg;
    assign prem   = (WID'(v4_reg) << swrs_pkg::TWO_PI_SHIFT) - ares;

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign clear     = (state_reg == S_OUT) && m_tready && (k_reg == swrs_pkg::MET_PATH_2PI);
    assign arith_use = state_reg inside {S_HMA, S_HMB, S_HSQ, S_TM, S_NN, S_MNN,
                                         S_VMUL, S_RSQ, S_DIV, S_SQ, S_RMUL, S_RBK};

    always_comb begin
        actl.start = arith_use && !issued_reg;
        actl.op    = swrs_pkg::ARITH_MUL;
        aa         = '0;
        ab         = '0;
        case (state_reg)
            S_HMA: begin
                aa = WID'(ha_reg);
                ab = WID'(ha_reg);
            end
            S_HMB: begin
                aa = WID'(hb_reg);
                ab = WID'(hb_reg);
            end
            S_HSQ: begin
                actl.op = swrs_pkg::ARITH_SQRT;
                aa      = WID'(hsum_reg) << swrs_pkg::HYP_FRAC_SHIFT;
            end
            S_TM: begin
                aa = WID'(t_reg);
                ab = WID'(m_val);
            end
            S_NN: begin
                aa = WID'(n_val);
                ab = WID'(n_val);
            end
            S_MNN: begin
                aa = WID'(m_val);
                ab = tmp_reg;
            end
            S_VMUL: begin
                aa = (k_reg == swrs_pkg::MET_XVEL) ? WID'(sstx_reg) : WID'(ssty_reg);
                ab = WID'(n_val);
            end
            S_RSQ: begin
                aa = WID'(e_reg);
                ab = WID'(e_reg);
            end
            S_RMUL: begin
                aa = WID'(swrs_pkg::TWO_PI_RECIP);
                ab = WID'(v4_reg);
            end
            S_RBK: begin
                aa = tmp_reg;
                ab = WID'(swrs_pkg::TWO_PI_Q29);
            end
            S_DIV: begin
                actl.op = swrs_pkg::ARITH_DIV;
                case (k_reg)
                    swrs_pkg::MET_XVEL, swrs_pkg::MET_YVEL: begin
                        aa = tmp_reg << swrs_pkg::FRAC_BITS;
                        ab = WID'(dvel_reg);
                    end
                    swrs_pkg::MET_PATH: begin
                        aa = WID'(spath_reg) << swrs_pkg::HYP_FRAC_SHIFT;
                        ab = WID'(t_reg);
                    end
                    swrs_pkg::MET_DIST: begin
                        aa = WID'(sdist_reg) << swrs_pkg::HYP_FRAC_SHIFT;
                        ab = WID'(t_reg);
                    end
                    swrs_pkg::MET_XRMS, swrs_pkg::MET_YRMS: begin
                        aa = WID'(q_reg) << swrs_pkg::RMS_SHIFT;
                        ab = WID'(drms_reg);
                    end
                    default: begin
                        ab = WID'(1);
                    end
                endcase
            end
            S_SQ: begin
                actl.op = swrs_pkg::ARITH_SQRT;
                aa      = tmp_reg;
            end
            default: begin
                actl.op = swrs_pkg::ARITH_MUL;
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        issued_next = (issued_reg || actl.start) && !arsp.done;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        xl_next     = xl_reg;
        xh_next     = xh_reg;
        yl_next     = yl_reg;
        yh_next     = yh_reg;
        t_next      = t_reg;
        sstx_next   = sstx_reg;
        ssty_next   = ssty_reg;
        spath_next  = spath_reg;
        sdist_next  = sdist_reg;
        sx_next     = sx_reg;
        sy_next     = sy_reg;
        sel_next    = sel_reg;
        last_next   = last_reg;
        k_next      = k_reg;
        bad_next    = bad_reg;
        idx_next    = idx_reg;
        prevx_next  = prevx_reg;
        prevy_next  = prevy_reg;
        ha_next     = ha_reg;
        hb_next     = hb_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        hsum_next   = hsum_reg;
        e_next      = e_reg;
        q_next      = q_reg;
        tmp_next    = tmp_reg;
        dvel_next   = dvel_reg;
        drms_next   = drms_reg;
        v4_next     = v4_reg;
        val_next    = val_reg;
        mem_we      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    last_next  = s_tlast;
                    state_next = s_tlast ? S_FIN : S_IDLE;
                    if (count_reg < CW'(MAX_SAMPLES)) begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        sx_next    = sx_reg + (SB+CW)'(xs);
                        sy_next    = sy_reg + (SB+CW)'(ys);
                        if (xs < xl_reg) xl_next = xs;
                        if (xs > xh_reg) xh_next = xs;
                        if (ys < yl_reg) yl_next = ys;
                        if (ys > yh_reg) yh_next = ys;
                        if (s_tdata[2*IW+TW-1:2*IW] > t_reg) begin
                            t_next = s_tdata[2*IW+TW-1:2*IW];
                        end
                        prevx_next = xs;
                        prevy_next = ys;
                        if (count_reg != '0) begin
                            ha_next    = adx[SB-1:0];
                            hb_next    = ady[SB-1:0];
                            pa_next    = apx[SB-1:0];
                            pb_next    = apy[SB-1:0];
                            sstx_next  = sstx_reg + (SB+CW)'(adx[SB-1:0]);
                            ssty_next  = ssty_reg + (SB+CW)'(ady[SB-1:0]);
                            sel_next   = 1'b0;
                            state_next = S_HMA;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
            end
            S_HMA: begin
                if (arsp.done) begin
                    hsum_next  = ares[2*SB:0];
                    state_next = S_HMB;
                end
            end
            S_HMB: begin
                if (arsp.done) begin
                    hsum_next  = hsum_reg + ares[2*SB:0];
                    state_next = S_HSQ;
                end
            end
            S_HSQ: begin
                if (arsp.done) begin
                    if (!sel_reg) begin
                        spath_next = spath_reg + (SB+CW+9)'(ares[SB+8:0]);
                        ha_next    = pa_reg;
                        hb_next    = pb_reg;
                        sel_next   = 1'b1;
                        state_next = S_HMA;
                    end else begin
                        sdist_next = sdist_reg + (SB+CW+8)'(ares[SB+8:0]);
                        state_next = last_reg ? S_FIN : S_IDLE;
                    end
                end
            end
            S_FIN: begin
                k_next   = swrs_pkg::MET_XRANGE;
                bad_next = bad;
                if (bad) begin
                    val_next   = '0;
                    state_next = S_OUT;
                end else begin
                    state_next = S_TM;
                end
            end
            S_TM: begin
                if (arsp.done) begin
                    dvel_next  = ares[TW+CW-1:0];
                    state_next = S_NN;
                end
            end
            S_NN: begin
                if (arsp.done) begin
                    tmp_next   = ares;
                    state_next = S_MNN;
                end
            end
            S_MNN: begin
                if (arsp.done) begin
                    drms_next  = ares[3*CW-1:0];
                    state_next = S_MST;
                end
            end
            S_MST: begin
                case (k_reg)
                    swrs_pkg::MET_XRANGE: begin
                        val_next   = {MB'(xdiff[SB-1:0])} << swrs_pkg::FRAC_BITS;
                        state_next = S_OUT;
                    end
                    swrs_pkg::MET_YRANGE: begin
                        val_next   = {MB'(ydiff[SB-1:0])} << swrs_pkg::FRAC_BITS;
                        state_next = S_OUT;
                    end
                    swrs_pkg::MET_XVEL, swrs_pkg::MET_YVEL: begin
                        state_next = S_VMUL;
                    end
                    swrs_pkg::MET_XRMS, swrs_pkg::MET_YRMS: begin
                        sel_next   = (k_reg == swrs_pkg::MET_YRMS);
                        idx_next   = '0;
                        q_next     = '0;
                        state_next = S_RRD;
                    end
                    swrs_pkg::MET_PATH_2PI: begin
                        state_next = S_RMUL;
                    end
                    default: begin
                        state_next = S_DIV;
                    end
                endcase
            end
            S_VMUL: begin
                if (arsp.done) begin
                    tmp_next   = ares;
                    state_next = S_DIV;
                end
            end
            S_RMUL: begin
                if (arsp.done) begin
                    tmp_next   = ares >> swrs_pkg::RECIP_SHIFT;
                    state_next = S_RBK;
                end
            end
            S_RBK: begin
                if (arsp.done) begin
                    val_next   = sat48(tmp_reg + ((prem >= WID'(swrs_pkg::TWO_PI_Q29)) ?
                                                  WID'(1) : WID'(0)));
                    state_next = S_OUT;
                end
            end
            S_RRD: begin
                state_next = S_RE;
            end
            S_RE: begin
                e_next     = eabs[SB+CW:0];
                state_next = S_RSQ;
            end
            S_RSQ: begin
                if (arsp.done) begin
                    q_next   = q_reg + ares[WQ-1:0];
                    idx_next = idx_reg + CW'(1);
                    state_next = (idx_reg + CW'(1) == m_val) ? S_DIV : S_RRD;
                end
            end
            S_DIV: begin
                if (arsp.done) begin
                    tmp_next = ares;
                    if (k_reg == swrs_pkg::MET_XRMS || k_reg == swrs_pkg::MET_YRMS) begin
                        state_next = S_SQ;
                    end else begin
                        val_next   = sat48(ares);
                        state_next = S_OUT;
                        if (k_reg == swrs_pkg::MET_PATH) v4_next = sat48(ares);
                    end
                end
            end
            S_SQ: begin
                if (arsp.done) begin
                    val_next   = sat48(ares);
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    if (k_reg == swrs_pkg::MET_PATH_2PI) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = swrs_pkg::metric_t'(k_reg + 4'd1);
                        state_next = bad_reg ? S_OUT : S_MST;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (clear) begin
            count_next = '0;
            ovf_next   = 1'b0;
            xl_next    = SMAX;
            yl_next    = SMAX;
            xh_next    = SMIN;
            yh_next    = SMIN;
            t_next     = '0;
            sstx_next  = '0;
            ssty_next  = '0;
            spath_next = '0;
            sdist_next = '0;
            sx_next    = '0;
            sy_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            issued_reg <= 1'b0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            xl_reg     <= SMAX;
            yl_reg     <= SMAX;
            xh_reg     <= SMIN;
            yh_reg     <= SMIN;
            t_reg      <= '0;
            sstx_reg   <= '0;
            ssty_reg   <= '0;
            spath_reg  <= '0;
            sdist_reg  <= '0;
            sx_reg     <= '0;
            sy_reg     <= '0;
            sel_reg    <= 1'b0;
            last_reg   <= 1'b0;
            k_reg      <= swrs_pkg::MET_XRANGE;
            bad_reg    <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            xl_reg     <= xl_next;
            yl_reg     <= yl_next;
            xh_reg     <= xh_next;
            yh_reg     <= yh_next;
            t_reg      <= t_next;
            sstx_reg   <= sstx_next;
            ssty_reg   <= ssty_next;
            spath_reg  <= spath_next;
            sdist_reg  <= sdist_next;
            sx_reg     <= sx_next;
            sy_reg     <= sy_next;
            sel_reg    <= sel_next;
            last_reg   <= last_next;
            k_reg      <= k_next;
            bad_reg    <= bad_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        prevx_reg <= prevx_next;
        prevy_reg <= prevy_next;
        ha_reg    <= ha_next;
        hb_reg    <= hb_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        hsum_reg  <= hsum_next;
        e_reg     <= e_next;
        q_reg     <= q_next;
        tmp_reg   <= tmp_next;
        dvel_reg  <= dvel_next;
        drms_reg  <= drms_next;
        v4_reg    <= v4_next;
        val_reg   <= val_next;
    end

    // writes happen only while loading; the read port reads every cycle, but its data is used only while closing
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            x_mem[count_reg[AW-1:0]] <= xs;
            y_mem[count_reg[AW-1:0]] <= ys;
        end
        rdx_reg <= x_mem[raddr];
        rdy_reg <= y_mem[raddr];
    end

    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = val_reg;
    assign m_tuser  = {bad_reg, k_reg};
    assign m_tlast  = (k_reg == swrs_pkg::MET_PATH_2PI);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a metric is pending");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[4]) |-> (m_tdata == '0))
        else $error("invalid metric carries a value");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tuser[3:0] == swrs_pkg::MET_PATH_2PI))
        else $error("last flag on the wrong metric");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_SAMPLES))
        else $error("sample count beyond capacity");

    a_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (count_reg == CW'(MAX_SAMPLES)) && !s_tlast) |=> ovf_reg)
        else $error("dropped sample did not mark overflow");

    a_arith_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        actl.start |-> !arsp.busy)
        else $error("arithmetic unit started while busy");

endmodule
